// ----- hw/rtl/coeff_pack11_stream_macros.svh -----
// Assertion macros for the 11-bit coefficient pack/unpack stream.
// Used by the port checker; depends on nothing else.
`ifndef COEFF_PACK11_STREAM_MACROS_SVH
`define COEFF_PACK11_STREAM_MACROS_SVH

// same-cycle implication
`define CP11_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cp11 assertion failed");

// next-cycle implication
`define CP11_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cp11 assertion failed");

`endif

// ----- hw/rtl/cp11_pkg.sv -----
// Shared constants and types for the 11-bit coefficient pack/unpack stream.
// No dependencies.
package cp11_pkg;

  localparam int COEFFS_PER_POLY = 256;
  localparam int FIELD_BITS      = 11;
  localparam int MODULUS         = 3329;

  localparam int COEFF_W    = 13;
  localparam int BYTE_W     = 8;
  localparam int BUF_W      = 18;
  localparam int CNT_W      = 5;
  localparam int ITEM_CNT_W = $clog2(COEFFS_PER_POLY);

  localparam logic [ITEM_CNT_W-1:0] ITEM_LAST = ITEM_CNT_W'(COEFFS_PER_POLY - 1);

  localparam logic MODE_PACK   = 1'b0;
  localparam logic MODE_UNPACK = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0]     byte_out;
    logic [FIELD_BITS-1:0] coeff_out;
    logic                  last;
  } res_t;

  // load request from the datapath into the result buffer
  typedef struct packed {
    logic       fire;
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } load_t;

endpackage

// ----- hw/rtl/cp11_if.sv -----
// Stream interfaces (valid/ready) for input items and results.
// Depends on cp11_pkg.
interface cp11_in_if;
  import cp11_pkg::*;
  logic               valid;
  logic               ready;
  logic [COEFF_W-1:0] coeff_in;
  logic [BYTE_W-1:0]  byte_in;

  modport source (output valid, output coeff_in, output byte_in, input ready);
  modport sink   (input valid, input coeff_in, input byte_in, output ready);
endinterface

interface cp11_out_if;
  import cp11_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [BYTE_W-1:0]     byte_out;
  logic [FIELD_BITS-1:0] coeff_out;
  logic                  last;

  modport source (output valid, output byte_out, output coeff_out, output last, input ready);
  modport sink   (input valid, input byte_out, input coeff_out, input last, output ready);
endinterface

// ----- hw/rtl/cp11_core.sv -----
// Input register, bit buffer state and pack/unpack datapath.
// Depends on cp11_pkg and cp11_in_if; feeds cp11_res_buf.
module cp11_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  cp11_in_if.sink         item,
  input  logic            load_ok,
  output cp11_pkg::load_t load
);
  import cp11_pkg::*;

  logic                  mode;
  logic                  iv;
  logic [COEFF_W-1:0]    coeff_q;
  logic [BYTE_W-1:0]     byte_q;
  logic [BUF_W-1:0]      bbuf, bbuf_next;
  logic [CNT_W-1:0]      bcnt, bcnt_next;
  logic [ITEM_CNT_W-1:0] icnt, icnt_next;

  logic                  fire;
  logic                  final_item;
  logic [FIELD_BITS-1:0] field;
  logic [BUF_W-1:0]      merged;
  logic [CNT_W-1:0]      total;

  assign fire       = iv && load_ok;
  assign item.ready = !iv || load_ok;
  assign final_item = (icnt == ITEM_LAST);

  // negative coefficient: add q, keep 11 bits
  assign field = coeff_q[COEFF_W-1] ? FIELD_BITS'(coeff_q + COEFF_W'(MODULUS))
                                    : coeff_q[FIELD_BITS-1:0];

  always_comb begin
    load      = '0;
    bbuf_next = bbuf;
    bcnt_next = bcnt;
    icnt_next = icnt;
    if (mode == MODE_PACK) begin
      merged = bbuf | (BUF_W'(field) << bcnt);
      total  = bcnt + CNT_W'(FIELD_BITS);
      load.r0.byte_out = merged[BYTE_W-1:0];
      if (total >= CNT_W'(2 * BYTE_W)) begin
        load.num         = 2'd2;
        load.r1.byte_out = merged[2*BYTE_W-1:BYTE_W];
        load.r1.last     = final_item;
        bbuf_next        = merged >> (2 * BYTE_W);
        bcnt_next        = total - CNT_W'(2 * BYTE_W);
      end else begin
        load.num     = 2'd1;
        load.r0.last = final_item;
        bbuf_next    = merged >> BYTE_W;
        bcnt_next    = total - CNT_W'(BYTE_W);
      end
      if (final_item) begin
        bbuf_next = '0;
        bcnt_next = '0;
        icnt_next = '0;
      end else begin
        icnt_next = icnt + 1'b1;
      end
    end else begin
      merged = bbuf | (BUF_W'(byte_q) << bcnt);
      total  = bcnt + CNT_W'(BYTE_W);
      if (total >= CNT_W'(FIELD_BITS)) begin
        load.num          = 2'd1;
        load.r0.coeff_out = merged[FIELD_BITS-1:0];
        load.r0.last      = final_item;
        bbuf_next         = merged >> FIELD_BITS;
        bcnt_next         = total - CNT_W'(FIELD_BITS);
        if (final_item) begin
          bbuf_next = '0;
          bcnt_next = '0;
          icnt_next = '0;
        end else begin
          icnt_next = icnt + 1'b1;
        end
      end else begin
        bbuf_next = merged;
        bcnt_next = total;
      end
    end
    load.fire = fire;
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      coeff_q <= item.coeff_in;
      byte_q  <= item.byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PACK;
      iv   <= 1'b0;
      bbuf <= '0;
      bcnt <= '0;
      icnt <= '0;
    end else begin
      if (item.valid && item.ready) begin
        iv <= 1'b1;
      end else if (fire) begin
        iv <= 1'b0;
      end
      if (fire) begin
        bbuf <= bbuf_next;
        bcnt <= bcnt_next;
        icnt <= icnt_next;
      end
      // mode write restarts the stream
      if (cfg_we) begin
        mode <= cfg_wdata;
        bbuf <= '0;
        bcnt <= '0;
        icnt <= '0;
      end
    end
  end

endmodule

// ----- hw/rtl/cp11_res_buf.sv -----
// Two-entry result buffer: holds the one or two results of an item.
// Depends on cp11_pkg and cp11_out_if; loaded by cp11_core.
module cp11_res_buf (
  input  logic            clk,
  input  logic            rst,
  input  cp11_pkg::load_t load,
  output logic            load_ok,
  cp11_out_if.source      result
);
  import cp11_pkg::*;

  res_t       r0;
  res_t       r1;
  logic [1:0] cnt;
  logic       pop;

  assign pop     = result.valid && result.ready;
  assign load_ok = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  assign result.valid     = (cnt != 2'd0);
  assign result.byte_out  = r0.byte_out;
  assign result.coeff_out = r0.coeff_out;
  assign result.last      = r0.last;

  always_ff @(posedge clk) begin
    if (load.fire) begin
      r0 <= load.r0;
      r1 <= load.r1;
    end else if (pop) begin
      r0 <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load.fire) begin
      cnt <= load.num;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

endmodule

// ----- hw/rtl/coeff_pack11_stream.sv -----
// 11-bit coefficient packer/unpacker, top level.
// Path from input request to first result: input register, then result buffer.
// Throughput: 1 input request per cycle while the result port accepts; a packed coefficient
// giving two bytes holds the input back, as the result port moves one byte per cycle.
// Reset (rst, synchronous): mode = pack, bit buffer and counters cleared, buffers empty.
module coeff_pack11_stream (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  cp11_in_if.sink    item,
  cp11_out_if.source result
);
  import cp11_pkg::*;

  load_t load;
  logic  load_ok;

  cp11_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .load_ok   (load_ok),
    .load      (load)
  );

  cp11_res_buf u_res_buf (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .load_ok (load_ok),
    .result  (result)
  );

endmodule

// ----- hw/rtl/cp11_checker.sv -----
// Port-level checker for coeff_pack11_stream, bound to the top level.
// Depends on cp11_pkg and coeff_pack11_stream_macros.svh.
`include "coeff_pack11_stream_macros.svh"

module cp11_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic                            cfg_wdata,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [cp11_pkg::BYTE_W-1:0]     byte_out,
  input logic [cp11_pkg::FIELD_BITS-1:0] coeff_out,
  input logic                            last
);
  import cp11_pkg::*;

  logic mode_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q <= MODE_PACK;
    end else if (cfg_we) begin
      mode_q <= cfg_wdata;
    end
  end

  `CP11_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(byte_out) && $stable(coeff_out) && $stable(last))
  `CP11_ASSERT_IMP(a_rst_empty, clk, 1'b0, !rst && $past(rst), !out_valid)
  `CP11_ASSERT_IMP(a_unpack_no_byte, clk, rst, out_valid && (mode_q == MODE_UNPACK), byte_out == '0)
  `CP11_ASSERT_IMP(a_pack_no_coeff, clk, rst, out_valid && (mode_q == MODE_PACK), coeff_out == '0)

endmodule

bind coeff_pack11_stream cp11_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .byte_out  (result.byte_out),
  .coeff_out (result.coeff_out),
  .last      (result.last)
);

// ----- tb/coeff_pack11_stream_check.sv -----
// Scoreboard for coeff_pack11_stream: follows mode writes and accepted requests,
// predicts the bytes or coefficients due and compares each result in order.
// Depends on cp11_pkg and the cp11_in_if / cp11_out_if stream interfaces.
module coeff_pack11_stream_check (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  cp11_in_if   item,
  cp11_out_if  result,
  output int   errors,
  output int   pending
);
  import cp11_pkg::*;

  logic             mode;
  logic [BUF_W-1:0] stream_bits;
  logic [CNT_W-1:0] stream_count;
  int unsigned      poly_pos;
  res_t             expected_q[$];
  int               mismatches = 0;

  function automatic void clear_stream();
    stream_bits  = '0;
    stream_count = '0;
    poly_pos     = 0;
  endfunction

  function automatic void flag(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected byte %02h coeff %03h last %0b, got byte %02h coeff %03h last %0b",
               $time, what, want.byte_out, want.coeff_out, want.last,
               got.byte_out, got.coeff_out, got.last);
  endfunction

  function automatic void predict_request(input logic [COEFF_W-1:0] c,
                                          input logic [BYTE_W-1:0] b);
    logic [31:0] acc;
    int          nbits;
    int          val;
    int          made;
    int          i;
    res_t        outs[2];
    acc     = 32'(stream_bits);
    nbits   = int'(stream_count);
    made    = 0;
    outs[0] = '0;
    outs[1] = '0;
    if (mode == MODE_PACK) begin
      val = int'($signed(c));
      if (val < 0) val += MODULUS;
      acc |= 32'(val[FIELD_BITS-1:0]) << nbits;
      nbits += FIELD_BITS;
      while (nbits >= 8 && made < 2) begin
        outs[made].byte_out = acc[7:0];
        acc >>= 8;
        nbits -= 8;
        made++;
      end
    end else begin
      acc |= 32'(b) << nbits;
      acc = 32'(acc[BUF_W-1:0]);
      nbits += 8;
      if (nbits >= FIELD_BITS) begin
        outs[0].coeff_out = acc[FIELD_BITS-1:0];
        acc >>= FIELD_BITS;
        nbits -= FIELD_BITS;
        made = 1;
      end
    end
    stream_bits  = acc[BUF_W-1:0];
    stream_count = CNT_W'(nbits);
    // pack counts coefficients taken, unpack counts coefficients emitted
    if (made > 0) begin
      if (poly_pos + 1 >= COEFFS_PER_POLY) begin
        outs[made-1].last = 1'b1;
        clear_stream();
      end else begin
        poly_pos++;
      end
    end
    for (i = 0; i < made; i++) expected_q.push_back(outs[i]);
  endfunction

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      mode = MODE_PACK;
      clear_stream();
      expected_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        got.byte_out  = result.byte_out;
        got.coeff_out = result.coeff_out;
        got.last      = result.last;
        if (expected_q.size() == 0) begin
          flag("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.byte_out !== want.byte_out || got.coeff_out !== want.coeff_out ||
              got.last !== want.last)
            flag("mismatch", want, got);
        end
      end
      if (cfg_we) begin
        mode = cfg_wdata;
        clear_stream();
      end
      if (item.valid && item.ready) predict_request(item.coeff_in, item.byte_in);
    end
    errors  <= mismatches;
    pending <= expected_q.size();
  end

endmodule

// ----- tb/coeff_pack11_stream_test.sv -----
// Top-level testbench for coeff_pack11_stream: clock, reset, mode writes and
// request/result traffic with random idling; verdict from the scoreboard.
// Depends on cp11_pkg, the stream interfaces and coeff_pack11_stream_check.
module coeff_pack11_stream_test;
  import cp11_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;
  logic quiet     = 1'b0;
  int   errors;
  int   pending;
  int   cycles        = 0;
  int   results_taken = 0;

  logic [COEFF_W-1:0] pack_edges [11] = '{
    13'(-3329), 13'(3328), 13'(0), 13'(-1), 13'(1), 13'(-4096), 13'(4095),
    13'(-3330), 13'(2047), 13'(2048), 13'(-2048)
  };
  logic [BYTE_W-1:0] unpack_edges [11] = '{
    8'h00, 8'hff, 8'hff, 8'h00, 8'h55, 8'haa, 8'h01, 8'h80, 8'hff, 8'hff, 8'hff
  };

  cp11_in_if  item_ch ();
  cp11_out_if res_ch ();

  always #5 clk = ~clk;

  coeff_pack11_stream dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (res_ch)
  );

  coeff_pack11_stream_check mon (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (res_ch),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (!rst && res_ch.valid && res_ch.ready) results_taken++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off once the pack stream is busy
  initial begin : sink_side
    int stall_left;
    bit held;
    stall_left   = 0;
    held         = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (!held && results_taken >= 600) begin
        held         = 1'b1;
        stall_left   = 400;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= quiet || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  function automatic logic [COEFF_W-1:0] random_coeff();
    if ($urandom_range(0, 9) == 0) return COEFF_W'($urandom);
    return COEFF_W'(int'($urandom_range(0, 2 * MODULUS - 1)) - MODULUS);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input logic [COEFF_W-1:0] c, input logic [BYTE_W-1:0] b);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      item_ch.valid    <= 1'b0;
      item_ch.coeff_in <= COEFF_W'($urandom);
      item_ch.byte_in  <= BYTE_W'($urandom);
      @(negedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.coeff_in <= c;
    item_ch.byte_in  <= b;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input logic m, input int count, input int quiet_from,
                              input int quiet_to);
    int i;
    set_mode(m);
    for (i = 0; i < count; i++) begin
      quiet = (i >= quiet_from && i < quiet_to);
      send(random_coeff(), BYTE_W'($urandom));
    end
    quiet = 1'b0;
  endtask

  initial begin : source_side
    int i;
    item_ch.valid    = 1'b0;
    item_ch.coeff_in = '0;
    item_ch.byte_in  = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_mode(MODE_PACK);
    for (i = 0; i < 11; i++) send(pack_edges[i], BYTE_W'($urandom));
    // mode write mid-polynomial drops the partial stream
    set_mode(MODE_UNPACK);
    for (i = 0; i < 11; i++) send(COEFF_W'($urandom), unpack_edges[i]);

    random_phase(MODE_PACK, 540, 100, 300);
    random_phase(MODE_UNPACK, 720, 0, 0);
    random_phase(MODE_UNPACK, 100, 0, 0);
    random_phase(MODE_PACK, 90, 0, 0);

    wait_drained();
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
